>>> hw/rtl/glrc_pkg.sv
// ---------------------------------------------------------------------------
// glrc_pkg
// Shared types and constants for the grid line road cell counter.
// ---------------------------------------------------------------------------
`default_nettype none

package glrc_pkg;

    localparam int ROW_LIMIT_DEF = 256;
    localparam int COL_LIMIT_DEF = 256;

    localparam int CoordW = 8;
    localparam int StrideW = 9;
    localparam int CountW = 9;
    // widest linear address: 255*511 + 255
    localparam int LinW = 17;
    // squared-distance accumulators of the walker
    localparam int AccW = 34;

    localparam logic [StrideW-1:0] STRIDE_RESET = 9'd256;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        WK_IDLE,
        WK_SETUP,
        WK_RUN
    } walk_state_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_WALK,
        TS_DRAIN
    } top_state_t;

    typedef struct packed {
        logic              valid;
        logic [CoordW-1:0] row;
        logic [CoordW-1:0] col;
    } step_t;

    typedef struct packed {
        logic              valid;
        logic              wr;
        logic [CoordW-1:0] row;
        logic [CoordW-1:0] col;
        logic [1:0]        marks;
    } map_op_t;

    typedef struct packed {
        logic valid;
        logic road;
    } map_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/glrc_walker.sv
// ---------------------------------------------------------------------------
// glrc_walker
// Line walker: produces one candidate cell per cycle using exact integer
// forms of floor(s*delta/sqrt(D)) kept by running sums.
// ---------------------------------------------------------------------------
`default_nettype none

module glrc_walker
    import glrc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [CoordW-1:0] start_row,
    input  wire logic [CoordW-1:0] start_col,
    input  wire logic [CoordW-1:0] end_row,
    input  wire logic [CoordW-1:0] end_col,
    output step_t                  step,
    output logic                   busy
);

    walk_state_t state_reg, state_next;

    logic [CoordW-1:0] sr_reg, sc_reg, dr_reg, dc_reg;
    logic              rup_reg, cup_reg;
    logic [LinW-1:0]   d_reg, s2_reg;
    logic [LinW:0]     d2_reg;
    logic [9:0]        s2inc_reg;
    logic [AccW-1:0]   pr_reg, princ_reg, pc_reg, pcinc_reg;
    logic [AccW-1:0]   qr_reg, qrinc_reg, qc_reg, qcinc_reg;
    logic [LinW-1:0]   tdr2_reg, tdc2_reg;
    logic [CoordW-1:0] kr_reg, kc_reg;

    logic              finished, kr_inc, kc_inc;
    logic [CoordW-1:0] kr_next, kc_next;
    logic [15:0]       dr2, dc2;
    logic [LinW-1:0]   dsum;

    assign finished = s2_reg > d_reg;
    assign kr_inc   = qr_reg <= pr_reg;
    assign kc_inc   = qc_reg <= pc_reg;
    assign kr_next  = kr_reg + CoordW'(kr_inc);
    assign kc_next  = kc_reg + CoordW'(kc_inc);
    assign dr2      = dr_reg * dr_reg;
    assign dc2      = dc_reg * dc_reg;
    assign dsum     = LinW'(dr2) + LinW'(dc2);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            WK_IDLE:
            begin
                if (start)
                    state_next = WK_SETUP;
            end
            WK_SETUP: state_next = WK_RUN;
            WK_RUN:
            begin
                if (finished)
                    state_next = WK_IDLE;
            end
            default: state_next = WK_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = state_reg != WK_IDLE;
        step.valid = (state_reg == WK_RUN) && !finished &&
                     ((kr_next != '0) || (kc_next != '0));
        step.row   = rup_reg ? sr_reg + kr_next : sr_reg - kr_next;
        step.col   = cup_reg ? sc_reg + kc_next : sc_reg - kc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= WK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == WK_IDLE && start)
        begin
            sr_reg  <= start_row;
            sc_reg  <= start_col;
            rup_reg <= end_row >= start_row;
            cup_reg <= end_col >= start_col;
            dr_reg  <= (end_row >= start_row) ? end_row - start_row : start_row - end_row;
            dc_reg  <= (end_col >= start_col) ? end_col - start_col : start_col - end_col;
        end
        else if (state_reg == WK_SETUP)
        begin
            // step s = 1, offsets 0
            d_reg     <= dsum;
            d2_reg    <= {dsum, 1'b0};
            s2_reg    <= LinW'(1);
            s2inc_reg <= 10'd3;
            pr_reg    <= AccW'(dr2);
            princ_reg <= AccW'(dr2) + AccW'({dr2, 1'b0});
            pc_reg    <= AccW'(dc2);
            pcinc_reg <= AccW'(dc2) + AccW'({dc2, 1'b0});
            tdr2_reg  <= {dr2, 1'b0};
            tdc2_reg  <= {dc2, 1'b0};
            qr_reg    <= AccW'(dsum);
            qrinc_reg <= AccW'(dsum) + AccW'({dsum, 1'b0});
            qc_reg    <= AccW'(dsum);
            qcinc_reg <= AccW'(dsum) + AccW'({dsum, 1'b0});
            kr_reg    <= '0;
            kc_reg    <= '0;
        end
        else if (state_reg == WK_RUN && !finished)
        begin
            s2_reg    <= s2_reg + LinW'(s2inc_reg);
            s2inc_reg <= s2inc_reg + 10'd2;
            pr_reg    <= pr_reg + princ_reg;
            princ_reg <= princ_reg + AccW'(tdr2_reg);
            pc_reg    <= pc_reg + pcinc_reg;
            pcinc_reg <= pcinc_reg + AccW'(tdc2_reg);
            kr_reg    <= kr_next;
            kc_reg    <= kc_next;
            // (k+1)^2*D bound moves only when the offset advances
            if (kr_inc)
            begin
                qr_reg    <= qr_reg + qrinc_reg;
                qrinc_reg <= qrinc_reg + AccW'(d2_reg);
            end
            if (kc_inc)
            begin
                qc_reg    <= qc_reg + qcinc_reg;
                qcinc_reg <= qcinc_reg + AccW'(d2_reg);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/glrc_map.sv
// ---------------------------------------------------------------------------
// glrc_map
// Cell map memory behind an address pipeline: row*stride + col, reduced
// modulo the map depth by reciprocal multiply and one correction.
// ---------------------------------------------------------------------------
`default_nettype none

module glrc_map
    import glrc_pkg::*;
#(
    parameter int ROW_LIMIT = ROW_LIMIT_DEF,
    parameter int COL_LIMIT = COL_LIMIT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [StrideW-1:0] stride,
    input  map_op_t                 op,
    output map_res_t                res,
    output logic                    busy
);

    localparam longint unsigned MapDepth = longint'(ROW_LIMIT) * longint'(COL_LIMIT);
    localparam int AW = $clog2(MapDepth);
    localparam int Shift = LinW + AW;
    localparam longint unsigned Recip = (64'd1 << Shift) / MapDepth;
    localparam int RW = $clog2(Recip + 1);
    localparam int PW = LinW + RW;

    logic [1:0] mem [MapDepth];

    logic [4:0]       v_reg;
    logic [3:0]       wr_reg;
    logic [1:0]       mk1_reg, mk2_reg, mk3_reg;
    logic [LinW-1:0]  x1_reg, x2_reg, x3_reg, qd3_reg;
    logic [PW-1:0]    p2_reg;
    logic [1:0]       rd5_reg;

    logic [LinW-1:0]  quot, rem, rem_fix;
    logic [AW-1:0]    addr;

    assign quot    = LinW'(p2_reg >> Shift);
    assign rem     = x3_reg - qd3_reg;
    assign rem_fix = (64'(rem) >= MapDepth) ? rem - LinW'(MapDepth) : rem;
    assign addr    = AW'(rem_fix);

    assign busy      = |v_reg;
    // read data lands in the cycle after the address stage
    assign res.valid = v_reg[3] && !wr_reg[3];
    assign res.road  = rd5_reg[0] && !rd5_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            wr_reg <= '0;
        end
        else
        begin
            v_reg  <= {v_reg[3:0], op.valid};
            wr_reg <= {wr_reg[2:0], op.wr};
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg  <= LinW'(32'(op.row) * 32'(stride) + 32'(op.col));
        mk1_reg <= op.marks;
        p2_reg  <= PW'(x1_reg) * PW'(Recip);
        x2_reg  <= x1_reg;
        mk2_reg <= mk1_reg;
        qd3_reg <= LinW'(64'(quot) * MapDepth);
        x3_reg  <= x2_reg;
        mk3_reg <= mk2_reg;
        if (v_reg[2] && wr_reg[2])
            mem[addr] <= mk3_reg;
        rd5_reg <= mem[addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/grid_line_road_cell_counter.sv
// ---------------------------------------------------------------------------
// grid_line_road_cell_counter
// Road cell count along a grid line between two cells of a stored map.
// ---------------------------------------------------------------------------
// Write item: no result; the next item may follow at once.
// Query: a setup state, then one step per cycle up to N = floor(sqrt(D)) (at most 360),
//   then the walk closes and the map pipeline drains; the result is presented
//   once the map is idle and the output register is free.
// One query at a time; the next item is taken with the result.
// Reset clears control state and the stride (256); map contents stay undefined.
`default_nettype none

module grid_line_road_cell_counter
    import glrc_pkg::*;
#(
    parameter int ROW_LIMIT = ROW_LIMIT_DEF,
    parameter int COL_LIMIT = COL_LIMIT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data,     // columns_in_use
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cell_row[7:0] cell_col[15:8] road_flag[16] pad_flag[17]
    // start_row[25:18] start_col[33:26] end_row[41:34] end_col[49:42]
    input  wire logic [55:0] s_tdata,
    input  wire logic        s_tuser,      // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata       // road_cells[8:0] checked_cells[17:9]
);

    top_state_t state_reg, state_next;

    logic [StrideW-1:0] stride_reg;
    logic [CountW-1:0]  road_reg, checked_reg;
    logic [23:0]        out_data_reg;
    logic               out_valid_reg;

    logic     accept, out_free, walk_busy, map_busy;
    step_t    step;
    map_op_t  op;
    map_res_t res;

    assign cfg_ready = 1'b1;
    assign s_tready  = state_reg == TS_IDLE;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    glrc_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && s_tuser == KIND_QUERY),
        .start_row (s_tdata[25:18]),
        .start_col (s_tdata[33:26]),
        .end_row   (s_tdata[41:34]),
        .end_col   (s_tdata[49:42]),
        .step      (step),
        .busy      (walk_busy)
    );

    always_comb
    begin
        if (step.valid)
        begin
            op.valid = 1'b1;
            op.wr    = 1'b0;
            op.row   = step.row;
            op.col   = step.col;
            op.marks = 2'b00;
        end
        else
        begin
            op.valid = accept && s_tuser == KIND_WRITE;
            op.wr    = 1'b1;
            op.row   = s_tdata[7:0];
            op.col   = s_tdata[15:8];
            op.marks = s_tdata[17:16];
        end
    end

    glrc_map #(
        .ROW_LIMIT (ROW_LIMIT),
        .COL_LIMIT (COL_LIMIT)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .stride (stride_reg),
        .op     (op),
        .res    (res),
        .busy   (map_busy)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TS_IDLE:
            begin
                if (accept && s_tuser == KIND_QUERY)
                    state_next = TS_WALK;
            end
            TS_WALK:
            begin
                if (!walk_busy)
                    state_next = TS_DRAIN;
            end
            TS_DRAIN:
            begin
                if (!map_busy && out_free)
                    state_next = TS_IDLE;
            end
            default: state_next = TS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TS_IDLE;
            stride_reg    <= STRIDE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                stride_reg <= cfg_data;
            if (state_reg == TS_DRAIN && !map_busy && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == KIND_QUERY)
        begin
            road_reg    <= '0;
            checked_reg <= '0;
        end
        else if (res.valid)
        begin
            road_reg    <= road_reg + CountW'(res.road);
            checked_reg <= checked_reg + CountW'(1);
        end
        if (state_reg == TS_DRAIN && !map_busy && out_free)
            out_data_reg <= {6'b0, checked_reg, road_reg};
    end

`ifndef ASSERT_OFF
    a_walker_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        walk_busy |-> (state_reg == TS_WALK))
        else $error("walker running outside a query");

    a_reads_only_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (state_reg == TS_WALK || state_reg == TS_DRAIN))
        else $error("map read result outside a query");

    a_road_within_checked: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[8:0] <= m_tdata[17:9]))
        else $error("road count above checked count");
`endif

endmodule

`default_nettype wire
